// ===== rtl/lpm_pkg.sv =====
// Package for the LIKE pattern match counter: item types, character codes and
// configuration register indexes. Used by every file of the block but lpm_closure.
package lpm_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned PAT_LEN_W     = 6;
  localparam int unsigned CHAR_W        = 8;
  localparam int unsigned WORD_CHARS    = 8;
  localparam int unsigned COUNT_OUT_W   = 32;

  // Register indexes: words 0 to 6 lie below the length register
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LENGTH = 3'd7;

  // Pattern characters with a special meaning
  localparam logic [CHAR_W-1:0] PCT_CHAR = 8'h25;
  localparam logic [CHAR_W-1:0] ANY_CHAR = 8'h5F;
  localparam logic [CHAR_W-1:0] NUL_CHAR = 8'h00;

  // One input item
  typedef struct packed {
    logic [CHAR_W-1:0] char_byte;
    logic              has_char;
    logic              end_of_value;
    logic              clear_count;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic                   matched;
    logic [COUNT_OUT_W-1:0] match_count;
  } out_item_t;

endpackage

// ===== rtl/lpm_if.sv =====
// Valid/ready channel interfaces for the input and result items.
// Depends on lpm_pkg for the payload types.
interface lpm_in_if;
  logic               valid;
  logic               ready;
  lpm_pkg::in_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface lpm_out_if;
  logic               valid;
  logic               ready;
  lpm_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/lpm_closure.sv =====
// Parallel prefix network that closes a position set over propagating positions.
// Bit i+1 is set wherever bit i is set and prop_i[i] is high. Depends on nothing.
module lpm_closure #(
  parameter int unsigned WIDTH = 57
) (
  input  logic [WIDTH-1:0] set_i,
  input  logic [WIDTH-2:0] prop_i,
  output logic [WIDTH-1:0] set_o
);

  localparam int unsigned LEVELS = (WIDTH > 2) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] gen_lv  [LEVELS+1];
  logic [WIDTH-1:0] prop_lv [LEVELS];

  // Kogge-Stone style levels: each level doubles the reach of a propagate run.
  always_comb begin
    gen_lv[0]  = set_i;
    prop_lv[0] = {prop_i, 1'b0};
    for (int l = 0; l < LEVELS; l++) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (i >= (1 << l)) begin
          gen_lv[l+1][i] = gen_lv[l][i] | (prop_lv[l][i] & gen_lv[l][i - (1 << l)]);
        end else begin
          gen_lv[l+1][i] = gen_lv[l][i];
        end
      end
      if (l < LEVELS - 1) begin
        for (int i = 0; i < WIDTH; i++) begin
          if (i >= (1 << l)) begin
            prop_lv[l+1][i] = prop_lv[l][i] & prop_lv[l][i - (1 << l)];
          end else begin
            prop_lv[l+1][i] = prop_lv[l][i];
          end
        end
      end
    end
  end

  assign set_o = gen_lv[LEVELS];

endmodule

// ===== rtl/lpm_pattern_regs.sv =====
// Pattern configuration registers and the masks derived from them.
// Depends on lpm_pkg and lpm_closure.
module lpm_pattern_regs #(
  parameter int unsigned MAX_PATTERN = 56
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         cfg_we_i,
  input  logic [lpm_pkg::CFG_IDX_W-1:0]                cfg_idx_i,
  input  logic [lpm_pkg::CFG_DATA_W-1:0]               cfg_data_i,
  output logic [MAX_PATTERN-1:0][lpm_pkg::CHAR_W-1:0]  pat_byte_o,
  output logic [MAX_PATTERN-1:0]                       pct_mask_o,
  output logic [MAX_PATTERN-1:0]                       any_mask_o,
  output logic [MAX_PATTERN-1:0]                       len_mask_o,
  output logic [MAX_PATTERN:0]                         end_hot_o
);

  localparam int unsigned IdxW  = lpm_pkg::CFG_IDX_W;
  localparam int unsigned LenW  = lpm_pkg::PAT_LEN_W;
  localparam int unsigned ChW   = lpm_pkg::CHAR_W;
  localparam int unsigned NPos  = MAX_PATTERN + 1;
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_PATTERN);

  logic [MAX_PATTERN-1:0][ChW-1:0] pat_q;
  logic [LenW-1:0]                 len_q;
  logic [LenW-1:0]                 lim;
  logic [MAX_PATTERN-1:0]          in_use;
  logic [NPos-1:0]                 reach;

  // Register writes: a word write updates the eight characters it holds.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= '0;
      len_q <= '0;
    end else if (cfg_we_i) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        if (cfg_idx_i == IdxW'(k >> 3)) begin
          pat_q[k] <= cfg_data_i[(k & 7) * ChW +: ChW];
        end
      end
      if (cfg_idx_i == lpm_pkg::CFG_IDX_LENGTH) begin
        len_q <= cfg_data_i[LenW-1:0];
      end
    end
  end

  // Clamp the length and classify each pattern character.
  assign lim = (len_q > MaxLen) ? MaxLen : len_q;

  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      in_use[k]     = (LenW'(k) < lim) && (pat_q[k] != lpm_pkg::NUL_CHAR);
      pct_mask_o[k] = (pat_q[k] == lpm_pkg::PCT_CHAR);
      any_mask_o[k] = (pat_q[k] == lpm_pkg::ANY_CHAR);
    end
  end

  // Position k is reachable when all characters below it are in use; the
  // effective length is the highest such position.
  lpm_closure #(
    .WIDTH (NPos)
  ) u_reach (
    .set_i  (NPos'(1)),
    .prop_i (in_use),
    .set_o  (reach)
  );

  assign pat_byte_o = pat_q;
  assign len_mask_o = reach[NPos-1:1];
  assign end_hot_o  = reach & ~{1'b0, reach[NPos-1:1]};

`ifndef ASSERT_OFF
  // Exactly one position marks the end of the effective pattern.
  a_end_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(end_hot_o))
    else $error("end position of the pattern is not one-hot");

  // The in-use positions form one run starting at position zero.
  a_len_thermo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_mask_o & (len_mask_o + 1'b1)) == '0)
    else $error("pattern length mask is not a contiguous run");
`endif

endmodule

// ===== rtl/lpm_step.sv =====
// Position-set update for one character, end-of-value test and match counter.
// Depends on lpm_pkg and lpm_closure.
module lpm_step #(
  parameter int unsigned MAX_PATTERN = 56,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         restart_i,
  input  logic                                         fire_i,
  input  lpm_pkg::in_item_t                            item_i,
  input  logic [MAX_PATTERN-1:0][lpm_pkg::CHAR_W-1:0]  pat_byte_i,
  input  logic [MAX_PATTERN-1:0]                       pct_mask_i,
  input  logic [MAX_PATTERN-1:0]                       any_mask_i,
  input  logic [MAX_PATTERN-1:0]                       len_mask_i,
  input  logic [MAX_PATTERN:0]                         end_hot_i,
  output lpm_pkg::out_item_t                           result_o
);

  localparam int unsigned NPos = MAX_PATTERN + 1;
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  logic [NPos-1:0]        act_q;
  logic                   fresh_q;
  logic [COUNT_WIDTH-1:0] total_q;

  logic [MAX_PATTERN-1:0] prop;
  logic [NPos-1:0]        start_set;
  logic [NPos-1:0]        cur_set;
  logic [NPos-1:0]        next_set;
  logic [NPos-1:0]        closed_set;
  logic [NPos-1:0]        sel_set;
  logic                   matched;
  logic [COUNT_WIDTH-1:0] tot_base;
  logic [COUNT_WIDTH-1:0] tot_new;

  // Only percent signs inside the effective pattern extend a position.
  assign prop = pct_mask_i & len_mask_i;

  lpm_closure #(
    .WIDTH (NPos)
  ) u_start (
    .set_i  (NPos'(1)),
    .prop_i (prop),
    .set_o  (start_set)
  );

  // A fresh value starts from the start set of the current pattern.
  assign cur_set = fresh_q ? start_set : act_q;

  // Advance every active position over the incoming character.
  always_comb begin
    next_set = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (cur_set[k] && len_mask_i[k]) begin
        if (pct_mask_i[k]) begin
          next_set[k] = 1'b1;
        end else if (any_mask_i[k] || (pat_byte_i[k] == item_i.char_byte)) begin
          next_set[k+1] = 1'b1;
        end
      end
    end
  end

  lpm_closure #(
    .WIDTH (NPos)
  ) u_close (
    .set_i  (next_set),
    .prop_i (prop),
    .set_o  (closed_set)
  );

  // The value matches when the full-pattern position is active at its end.
  assign sel_set = item_i.has_char ? closed_set : cur_set;
  assign matched = |(sel_set & end_hot_i);

  // Saturating match total, cleared ahead of this item on request.
  assign tot_base = item_i.clear_count ? '0 : total_q;
  assign tot_new  = tot_base +
                    COUNT_WIDTH'(item_i.end_of_value && matched && (tot_base != CountMax));

  assign result_o.matched     = matched;
  assign result_o.match_count = lpm_pkg::COUNT_OUT_W'(64'(tot_new));

  // State update when an item leaves the input register, or on a restart.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= '0;
      fresh_q <= 1'b1;
      total_q <= '0;
    end else begin
      if (restart_i) begin
        fresh_q <= 1'b1;
      end else if (fire_i) begin
        if (item_i.end_of_value) begin
          fresh_q <= 1'b1;
        end else if (item_i.has_char) begin
          act_q   <= closed_set;
          fresh_q <= 1'b0;
        end
      end
      if (fire_i && (item_i.clear_count || item_i.end_of_value)) begin
        total_q <= tot_new;
      end
    end
  end

`ifndef ASSERT_OFF
  // A finished value always leaves the next one to start afresh.
  a_eov_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.end_of_value) |=> fresh_q)
    else $error("value ended but position set was not restarted");

  // Without a clear the match total never goes down.
  a_total_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !item_i.clear_count) |=> (total_q >= $past(total_q)))
    else $error("match total decreased without a clear");
`endif

endmodule

// ===== rtl/like_pattern_match_counter.sv =====
// LIKE pattern match counter: top level with input register and result register.
// A result passes through the input register and then the result register.
// Throughput: one item per cycle while results can move on; the position-set update is bit logic.
// Reset (asynchronous, active low) clears the pattern, the match total and the valid
// flags of both pipeline registers; the block is ready for items once reset is released.
// Depends on lpm_pkg, lpm_if, lpm_pattern_regs and lpm_step.
module like_pattern_match_counter #(
  parameter int unsigned MAX_PATTERN = 56,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lpm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lpm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  lpm_in_if.sink                          in_chan,
  lpm_out_if.source                       out_chan
);

  logic [MAX_PATTERN-1:0][lpm_pkg::CHAR_W-1:0] pat_byte;
  logic [MAX_PATTERN-1:0] pct_mask;
  logic [MAX_PATTERN-1:0] any_mask;
  logic [MAX_PATTERN-1:0] len_mask;
  logic [MAX_PATTERN:0]   end_hot;

  logic                 s1_v_q;
  lpm_pkg::in_item_t    s1_item_q;
  logic                 out_v_q;
  lpm_pkg::out_item_t   out_item_q;
  lpm_pkg::out_item_t   result;

  logic out_free;
  logic s1_fire;
  logic s1_emit;
  logic in_acc;

  // Pattern registers and derived masks
  lpm_pattern_regs #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_pattern (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pat_byte_o (pat_byte),
    .pct_mask_o (pct_mask),
    .any_mask_o (any_mask),
    .len_mask_o (len_mask),
    .end_hot_o  (end_hot)
  );

  // Handshake: an item leaves the input register unless its result has nowhere to go.
  assign out_free      = !out_v_q || out_chan.ready;
  assign s1_fire       = s1_v_q && (!s1_item_q.end_of_value || out_free);
  assign s1_emit       = s1_fire && s1_item_q.end_of_value;
  assign in_chan.ready = !s1_v_q || s1_fire;
  assign in_acc        = in_chan.valid && in_chan.ready;

  // Matcher state and counter
  lpm_step #(
    .MAX_PATTERN (MAX_PATTERN),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (cfg_we_i),
    .fire_i     (s1_fire),
    .item_i     (s1_item_q),
    .pat_byte_i (pat_byte),
    .pct_mask_i (pct_mask),
    .any_mask_i (any_mask),
    .len_mask_i (len_mask),
    .end_hot_i  (end_hot),
    .result_o   (result)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_acc) begin
      s1_v_q <= 1'b1;
    end else if (s1_fire) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_chan.payload;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_emit) begin
      out_v_q <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_emit) begin
      out_item_q <= result;
    end
  end

  assign out_chan.valid   = out_v_q;
  assign out_chan.payload = out_item_q;

`ifndef ASSERT_OFF
  // The input side stalls only behind a finished value whose result cannot move.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_chan.ready |-> (s1_v_q && s1_item_q.end_of_value && out_v_q && !out_chan.ready))
    else $error("input stalled without a blocked result");

  // Every finished value puts a result in the output register.
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_emit |=> out_v_q)
    else $error("finished value produced no result");
`endif

endmodule
